@@ hw/rtl/kacm_pkg.sv @@
// Shared types and codes for the keyed alignment column merge unit.
// No dependencies; imported by the top level and the bench.
package kacm_pkg;

  localparam int CELL_W = 16;

  typedef logic signed [CELL_W-1:0] cell_t;

  localparam cell_t GAP_CELL = '1;

  // request codes on req_type
  localparam logic [1:0] REQ_LOAD_ONE = 2'd0;
  localparam logic [1:0] REQ_LOAD_TWO = 2'd1;
  localparam logic [1:0] REQ_MERGE    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS_ONE    = 2'd0;
  localparam logic [1:0] REG_ROWS_TWO    = 2'd1;
  localparam logic [1:0] REG_KEY_ROW_ONE = 2'd2;
  localparam logic [1:0] REG_KEY_ROW_TWO = 2'd3;

endpackage

@@ hw/rtl/keyed_alignment_column_merge_unit.sv @@
// Top level of the keyed alignment column merge unit: two column stores and
// the two-pointer merge sequencer. Depends on kacm_pkg and kacm_ram.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | input     | in_valid/in_stall  | req_type, cell_a..cell_d
//   out     | output    | out_valid/out_stall| first_a..d, second_a..d, last_column
//   cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// A merge start reads the heads of both stores, then emits one merged column
// per cycle while the output is not stalled; that rate is set by the registered
// read of the two stores, whose next addresses are chosen from the pointer
// update of the current column.
// Input is stalled while a merge runs. An output stall holds the result
// register and the merge pointers. Reset clears counts, pointers and valid;
// store contents are not cleared.
module keyed_alignment_column_merge_unit
  import kacm_pkg::*;
#(
  parameter int MAX_COLS   = 32,
  parameter int ROWS       = 4,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  cell_t       cell_a,
  input  cell_t       cell_b,
  input  cell_t       cell_c,
  input  cell_t       cell_d,
  output logic        out_valid,
  input  logic        out_stall,
  output cell_t       first_a,
  output cell_t       first_b,
  output cell_t       first_c,
  output cell_t       first_d,
  output cell_t       second_a,
  output cell_t       second_b,
  output cell_t       second_c,
  output cell_t       second_d,
  output logic        last_column,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int WORD_W = ROWS * INDEX_BITS;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic             state, state_next;
  logic [2:0]       rows_one, rows_two;
  logic [1:0]       key_row_one, key_row_two;
  logic [CNT_W-1:0] count_one, count_two;
  logic [CNT_W-1:0] ptr_one, ptr_two, ptr_one_next, ptr_two_next;

  logic              in_fire, fire, last_next;
  logic              we_one, we_two;
  logic [WORD_W-1:0] wdata, rdata_one, rdata_two;

  cell_t in_cells [4];
  cell_t col_next [8];
  cell_t col      [8];

  logic signed [INDEX_BITS-1:0] row_one [ROWS];
  logic signed [INDEX_BITS-1:0] row_two [ROWS];
  logic signed [INDEX_BITS-1:0] key_one, key_two;
  logic [1:0] ksel_one, ksel_two;
  logic has_one, has_two, gap_one, gap_two, join_both, take_one;
  logic sel_one, sel_two;

  assign in_cells[0] = cell_a;
  assign in_cells[1] = cell_b;
  assign in_cells[2] = cell_c;
  assign in_cells[3] = cell_d;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign fire     = (state == ST_MERGE) && (!out_valid || !out_stall);

  assign we_one = in_fire && (req_type == REQ_LOAD_ONE) && (count_one < CNT_W'(MAX_COLS));
  assign we_two = in_fire && (req_type == REQ_LOAD_TWO) && (count_two < CNT_W'(MAX_COLS));

  // cut each cell to the stored index width
  for (genvar r = 0; r < ROWS; r++) begin : g_pack
    assign wdata[r*INDEX_BITS +: INDEX_BITS] = in_cells[r][INDEX_BITS-1:0];
    assign row_one[r] = rdata_one[r*INDEX_BITS +: INDEX_BITS];
    assign row_two[r] = rdata_two[r*INDEX_BITS +: INDEX_BITS];
  end

  kacm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_COLS)) u_store_one (
    .clk   (clk),
    .we    (we_one),
    .waddr (count_one[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (ptr_one_next[ADDR_W-1:0]),
    .rdata (rdata_one)
  );

  kacm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_COLS)) u_store_two (
    .clk   (clk),
    .we    (we_two),
    .waddr (count_two[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (ptr_two_next[ADDR_W-1:0]),
    .rdata (rdata_two)
  );

  // key rows past the stored rows saturate to the top row
  assign ksel_one = (32'(key_row_one) >= ROWS) ? 2'(ROWS - 1) : key_row_one;
  assign ksel_two = (32'(key_row_two) >= ROWS) ? 2'(ROWS - 1) : key_row_two;

  always_comb begin
    key_one = row_one[0];
    key_two = row_two[0];
    for (int r = 0; r < ROWS; r++) begin
      if (2'(r) == ksel_one) key_one = row_one[r];
      if (2'(r) == ksel_two) key_two = row_two[r];
    end
  end

  assign has_one   = ptr_one < count_one;
  assign has_two   = ptr_two < count_two;
  assign gap_one   = (key_one == '1);
  assign gap_two   = (key_two == '1);
  assign join_both = (gap_one && gap_two) || (!gap_one && !gap_two && key_one == key_two);
  assign take_one  = gap_one || (!gap_two && key_one < key_two);
  assign sel_one   = has_one && (!has_two || join_both || take_one);
  assign sel_two   = has_two && (!has_one || join_both || !take_one);

  always_comb begin
    ptr_one_next = ptr_one;
    ptr_two_next = ptr_two;
    state_next   = state;
    if (state == ST_IDLE) begin
      if (in_fire && req_type == REQ_MERGE) begin
        ptr_one_next = '0;
        ptr_two_next = '0;
        if (count_one != '0 || count_two != '0) state_next = ST_MERGE;
      end
    end else if (fire) begin
      ptr_one_next = ptr_one + CNT_W'(sel_one);
      ptr_two_next = ptr_two + CNT_W'(sel_two);
      if (last_next) state_next = ST_IDLE;
    end
  end

  assign last_next = (ptr_one_next >= count_one) && (ptr_two_next >= count_two);

  // merged column: rows out of use and absent sides read as gaps
  for (genvar r = 0; r < 4; r++) begin : g_col
    if (r < ROWS) begin : g_used
      assign col_next[r] = (sel_one && 3'(r) < rows_one) ?
                           cell_t'($signed(row_one[r])) : GAP_CELL;
      assign col_next[4+r] = (sel_two && 3'(r) < rows_two) ?
                             cell_t'($signed(row_two[r])) : GAP_CELL;
    end else begin : g_unused
      assign col_next[r]   = GAP_CELL;
      assign col_next[4+r] = GAP_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count_one   <= '0;
      count_two   <= '0;
      ptr_one     <= '0;
      ptr_two     <= '0;
      out_valid   <= 1'b0;
      rows_one    <= 3'd1;
      rows_two    <= 3'd1;
      key_row_one <= 2'd0;
      key_row_two <= 2'd0;
    end else begin
      state   <= state_next;
      ptr_one <= ptr_one_next;
      ptr_two <= ptr_two_next;
      if (we_one) count_one <= count_one + CNT_W'(1);
      if (we_two) count_two <= count_two + CNT_W'(1);
      // empty both stores once the merge is done, empty or not
      if ((state == ST_IDLE && in_fire && req_type == REQ_MERGE &&
           count_one == '0 && count_two == '0) || (fire && last_next)) begin
        count_one <= '0;
        count_two <= '0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS_ONE:    rows_one    <= cfg_data;
          REG_ROWS_TWO:    rows_two    <= cfg_data;
          REG_KEY_ROW_ONE: key_row_one <= cfg_data[1:0];
          REG_KEY_ROW_TWO: key_row_two <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      col         <= col_next;
      last_column <= last_next;
    end
  end

  assign first_a  = col[0];
  assign first_b  = col[1];
  assign first_c  = col[2];
  assign first_d  = col[3];
  assign second_a = col[4];
  assign second_b = col[5];
  assign second_c = col[6];
  assign second_d = col[7];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_one <= CNT_W'(MAX_COLS) && count_two <= CNT_W'(MAX_COLS))
    else $error("store count beyond capacity");

  a_merge_has_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> (has_one || has_two))
    else $error("merge running with both stores exhausted");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> (ptr_one <= count_one && ptr_two <= count_two))
    else $error("merge pointer past store count");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && last_next) |=> (state == ST_IDLE && count_one == '0 && count_two == '0
                             && out_valid && last_column))
    else $error("last column did not end the merge");

  a_emit_side: assert property (@(posedge clk) disable iff (rst)
    fire |-> (sel_one || sel_two))
    else $error("merged column with neither side");

endmodule

@@ hw/rtl/kacm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kacm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/keyed_alignment_column_merge_unit_tb.sv @@
// Self-checking bench for the keyed alignment column merge unit: column loads,
// merge starts and register writes, each merged word checked against a model.
// Depends on kacm_pkg and the unit's RTL.
module keyed_alignment_column_merge_unit_tb;
  import kacm_pkg::*;

  localparam int MAX_COLS     = 32;
  localparam int ROWS         = 4;
  localparam int ITEM_TARGET  = 460;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    cell_t [3:0] cells;
  } column_req_t;

  typedef struct packed {
    cell_t [3:0] side_one;
    cell_t [3:0] side_two;
    logic        last_col;
  } merged_col_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_LOAD_ONE;
  cell_t       cell_a = '0;
  cell_t       cell_b = '0;
  cell_t       cell_c = '0;
  cell_t       cell_d = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  cell_t       first_a, first_b, first_c, first_d;
  cell_t       second_a, second_b, second_c, second_d;
  logic        last_column;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_ROWS_ONE;
  logic [2:0]  cfg_data = '0;

  keyed_alignment_column_merge_unit #(
    .MAX_COLS  (MAX_COLS),
    .ROWS      (ROWS),
    .INDEX_BITS(16)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .cell_a     (cell_a),
    .cell_b     (cell_b),
    .cell_c     (cell_c),
    .cell_d     (cell_d),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .first_a    (first_a),
    .first_b    (first_b),
    .first_c    (first_c),
    .first_d    (first_d),
    .second_a   (second_a),
    .second_b   (second_b),
    .second_c   (second_c),
    .second_d   (second_d),
    .last_column(last_column),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // model state: column stores, fill counts and register copies
  cell_t       store_one [MAX_COLS][4];
  cell_t       store_two [MAX_COLS][4];
  int          fill_one = 0;
  int          fill_two = 0;
  logic [2:0]  rows_one_q = 3'd1;
  logic [2:0]  rows_two_q = 3'd1;
  logic [1:0]  key_one_q = 2'd0;
  logic [1:0]  key_two_q = 2'd0;

  merged_col_t merged_due [$];
  column_req_t pending_reqs [$];
  column_req_t in_item;
  bit          in_held = 1'b0;
  merged_col_t due_col;

  int error_count = 0;
  int queued_items = 0;
  int cycle_count = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;
  int out_draw;

  // key rows as the bench wrote them, used to build ordered columns
  int gen_key_one = 0;
  int gen_key_two = 0;

  function automatic int rows_in_use(logic [2:0] r);
    return (r > ROWS) ? ROWS : int'(r);
  endfunction

  function automatic int key_in_use(logic [1:0] k);
    return (k >= ROWS) ? ROWS - 1 : int'(k);
  endfunction

  // a negative index leaves that side all gaps
  function automatic merged_col_t join_column(int a, int b);
    merged_col_t col;
    int ra, rb;
    ra = rows_in_use(rows_one_q);
    rb = rows_in_use(rows_two_q);
    col.last_col = 1'b0;
    for (int r = 0; r < 4; r++) begin
      col.side_one[r] = (a >= 0 && r < ra) ? store_one[a][r] : GAP_CELL;
      col.side_two[r] = (b >= 0 && r < rb) ? store_two[b][r] : GAP_CELL;
    end
    return col;
  endfunction

  task automatic merge_columns();
    merged_col_t cols [$];
    int i, j, k1, k2;
    cell_t x, y;
    bit gx, gy;
    i = 0;
    j = 0;
    k1 = key_in_use(key_one_q);
    k2 = key_in_use(key_two_q);
    while (i < fill_one && j < fill_two) begin
      x = store_one[i][k1];
      y = store_two[j][k2];
      gx = (x == GAP_CELL);
      gy = (y == GAP_CELL);
      if ((gx && gy) || (!gx && !gy && x == y)) begin
        cols.push_back(join_column(i, j));
        i++;
        j++;
      end else if (gx || (!gy && x < y)) begin
        cols.push_back(join_column(i, -1));
        i++;
      end else begin
        cols.push_back(join_column(-1, j));
        j++;
      end
    end
    for (; i < fill_one; i++) cols.push_back(join_column(i, -1));
    for (; j < fill_two; j++) cols.push_back(join_column(-1, j));
    if (cols.size() > 0) cols[cols.size() - 1].last_col = 1'b1;
    foreach (cols[n]) merged_due.push_back(cols[n]);
    fill_one = 0;
    fill_two = 0;
  endtask

  task automatic apply_request(column_req_t it);
    case (it.kind)
      REQ_LOAD_ONE: begin
        if (fill_one < MAX_COLS) begin
          for (int r = 0; r < 4; r++) store_one[fill_one][r] = it.cells[r];
          fill_one++;
        end
      end
      REQ_LOAD_TWO: begin
        if (fill_two < MAX_COLS) begin
          for (int r = 0; r < 4; r++) store_two[fill_two][r] = it.cells[r];
          fill_two++;
        end
      end
      REQ_MERGE: merge_columns();
      default: ;
    endcase
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic cell_t rand_cell();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return GAP_CELL;
    if (r == 2) return cell_t'(0);
    if (r == 3) return cell_t'(32767);
    if (r < 7) return cell_t'($urandom_range(0, 7));
    return cell_t'($urandom_range(0, 32767));
  endfunction

  task automatic queue_col(logic [1:0] kind, cell_t a, cell_t b, cell_t c, cell_t d);
    column_req_t it;
    it.kind = kind;
    it.cells[0] = a;
    it.cells[1] = b;
    it.cells[2] = c;
    it.cells[3] = d;
    pending_reqs.push_back(it);
    if (kind != REQ_UNUSED) queued_items++;
  endtask

  // load two alignments, mostly with rising keys and scattered gaps, then merge
  task automatic queue_set(int n1, int n2);
    column_req_t it;
    bit ordered, to_one;
    int key1, key2;
    ordered = ($urandom_range(0, 7) != 0);
    key1 = ($urandom_range(0, 9) == 0) ? 32700 : $urandom_range(0, 3);
    key2 = key1 + $urandom_range(0, 2);
    while (n1 > 0 || n2 > 0) begin
      to_one = (n1 > 0) && (n2 == 0 || $urandom_range(0, 1) == 1);
      it.kind = to_one ? REQ_LOAD_ONE : REQ_LOAD_TWO;
      for (int r = 0; r < 4; r++) it.cells[r] = rand_cell();
      if ($urandom_range(0, 4) != 0) begin
        if (!ordered) begin
          it.cells[to_one ? gen_key_one : gen_key_two] = cell_t'($urandom_range(0, 7));
        end else if (to_one) begin
          key1 += $urandom_range(0, 2);
          it.cells[gen_key_one] = cell_t'(key1);
        end else begin
          key2 += $urandom_range(0, 2);
          it.cells[gen_key_two] = cell_t'(key2);
        end
      end else begin
        it.cells[to_one ? gen_key_one : gen_key_two] = GAP_CELL;
      end
      pending_reqs.push_back(it);
      queued_items++;
      if (to_one) n1--;
      else n2--;
      if ($urandom_range(0, 19) == 0) begin
        queue_col(REQ_UNUSED, rand_cell(), rand_cell(), rand_cell(), rand_cell());
      end
    end
    queue_col(REQ_MERGE, rand_cell(), rand_cell(), rand_cell(), rand_cell());
  endtask

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_config(logic [2:0] r1, logic [2:0] r2, logic [1:0] k1,
                                logic [1:0] k2);
    write_reg(REG_ROWS_ONE, r1);
    write_reg(REG_ROWS_TWO, r2);
    write_reg(REG_KEY_ROW_ONE, {1'b0, k1});
    write_reg(REG_KEY_ROW_TWO, {1'b0, k2});
    cfg_write <= 1'b0;
    gen_key_one = key_in_use(k1);
    gen_key_two = key_in_use(k2);
  endtask

  // hold until every word is sent and every merged column has come back
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_held || merged_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_cell(string name, cell_t want, cell_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && cfg_write) begin
      case (cfg_index)
        REG_ROWS_ONE:    rows_one_q <= cfg_data;
        REG_ROWS_TWO:    rows_two_q <= cfg_data;
        REG_KEY_ROW_ONE: key_one_q  <= cfg_data[1:0];
        REG_KEY_ROW_TWO: key_two_q  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        apply_request(in_item);
        in_held = 1'b0;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_item = pending_reqs.pop_front();
          in_held = 1'b1;
          req_type <= in_item.kind;
          cell_a   <= in_item.cells[0];
          cell_b   <= in_item.cells[1];
          cell_c   <= in_item.cells[2];
          cell_d   <= in_item.cells[3];
          in_valid <= 1'b1;
          if (in_calm > 0) begin
            in_calm = in_calm - 1;
            in_gap = 0;
          end else begin
            in_gap = pick_idle();
            if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 100);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall pattern
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_stall <= 1'b1;
    end else begin
      if (out_calm > 0) begin
        out_calm = out_calm - 1;
        out_draw = 0;
      end else begin
        out_draw = pick_idle();
        if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(20, 100);
      end
      out_stall <= (out_draw > 0);
      out_hold = (out_draw > 0) ? out_draw - 1 : 0;
    end
  end

  // monitor: compare each accepted word with the oldest expected column
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (merged_due.size() == 0) begin
        $error("merged column with none expected: first_a %0d second_a %0d", first_a,
               second_a);
        error_count++;
      end else begin
        due_col = merged_due.pop_front();
        check_cell("first_a", due_col.side_one[0], first_a);
        check_cell("first_b", due_col.side_one[1], first_b);
        check_cell("first_c", due_col.side_one[2], first_c);
        check_cell("first_d", due_col.side_one[3], first_d);
        check_cell("second_a", due_col.side_two[0], second_a);
        check_cell("second_b", due_col.side_two[1], second_b);
        check_cell("second_c", due_col.side_two[2], second_c);
        check_cell("second_d", due_col.side_two[3], second_d);
        if (last_column !== due_col.last_col) begin
          $error("last_column: expected %0d, got %0d", due_col.last_col, last_column);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int phase, phase_goal, n1, n2, r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset register values; empty merge and the unused code first
    queue_col(REQ_MERGE, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_col(REQ_UNUSED, GAP_CELL, GAP_CELL, GAP_CELL, GAP_CELL);
    // both keys gaps, equal keys, one gap on either side, each side smaller
    queue_col(REQ_LOAD_ONE, GAP_CELL, GAP_CELL, GAP_CELL, GAP_CELL);
    queue_col(REQ_LOAD_TWO, GAP_CELL, 16'sd1, 16'sd2, 16'sd3);
    queue_col(REQ_LOAD_ONE, 16'sd5, 16'sd32767, 16'sd0, GAP_CELL);
    queue_col(REQ_LOAD_TWO, 16'sd5, 16'sd0, 16'sd32767, GAP_CELL);
    queue_col(REQ_LOAD_ONE, 16'sd7, 16'sd6, 16'sd5, 16'sd4);
    queue_col(REQ_LOAD_TWO, GAP_CELL, 16'sd9, 16'sd8, 16'sd7);
    queue_col(REQ_LOAD_ONE, GAP_CELL, 16'sd11, 16'sd12, 16'sd13);
    queue_col(REQ_LOAD_TWO, 16'sd9, 16'sd14, 16'sd15, 16'sd16);
    queue_col(REQ_LOAD_ONE, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    queue_col(REQ_LOAD_TWO, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_col(REQ_LOAD_ONE, 16'sd20, 16'sd21, 16'sd22, 16'sd23);
    queue_col(REQ_MERGE, GAP_CELL, GAP_CELL, GAP_CELL, GAP_CELL);
    // leftovers with the other store empty
    queue_col(REQ_LOAD_TWO, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
    queue_col(REQ_LOAD_TWO, 16'sd2, 16'sd3, 16'sd4, 16'sd5);
    queue_col(REQ_MERGE, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    queue_col(REQ_LOAD_ONE, 16'sd32767, GAP_CELL, 16'sd0, 16'sd32767);
    queue_col(REQ_MERGE, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    phase = 1;
    while (queued_items < ITEM_TARGET) begin
      case (phase)
        1: program_config(3'd4, 3'd4, 2'd3, 2'd3);
        2: program_config(3'd0, 3'd7, 2'd0, 2'd3);
        3: program_config(3'd7, 3'd0, 2'd2, 2'd1);
        4: program_config(3'd2, 3'd3, 2'd1, 2'd0);
        default: program_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      endcase
      // fill store one past capacity and store two to capacity once
      if (phase == 1) queue_set(MAX_COLS + 1 + $urandom_range(0, 2), MAX_COLS);
      phase_goal = queued_items + 45;
      while (queued_items < phase_goal) begin
        r = $urandom_range(0, 29);
        n1 = (r == 0) ? 0 : (r == 1) ? $urandom_range(20, 34) : $urandom_range(1, 6);
        r = $urandom_range(0, 29);
        n2 = (r == 0) ? 0 : (r == 1) ? $urandom_range(20, 34) : $urandom_range(1, 6);
        queue_set(n1, n2);
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
